FILE: rtl/core/i2c_register_access_master_top_macros.svh
// Assertion macros shared by the register-access I2C master RTL.
// Depends on nothing; included by i2c_register_access_master_top.sv, which carries assertions.
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CRAM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define I2CRAM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/i2cram_pkg.sv
// Package for the register-access I2C master: bus phase and byte stage types,
// command codes and field widths. Depends on nothing.
package i2cram_pkg;

    // Command codes carried in the mode field.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam int unsigned ADDR_W   = 7;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BITCNT_W = 4;
    localparam int unsigned S_DATA_W = 24;
    localparam int unsigned M_DATA_W = 16;

    // One bus-line change per phase.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_TX_SET,
        PH_TX_HIGH,
        PH_TX_LOW,
        PH_ACK_REL,
        PH_ACK_HIGH,
        PH_ACK_LOW,
        PH_RS_HIGH,
        PH_RS_SDA,
        PH_RS_LOW,
        PH_RX_HIGH,
        PH_RX_LOW,
        PH_SP_SDA,
        PH_SP_SCL,
        PH_SP_END
    } phase_t;

    // Which byte of the transaction is on the wire.
    typedef enum logic [1:0] {
        STAGE_ADDR_W,
        STAGE_REG,
        STAGE_DATA,
        STAGE_ADDR_R
    } stage_t;

endpackage

FILE: rtl/core/i2c_register_access_master_top.sv
// Register-access I2C master, stepped one bus-line change per input item.
// Depends on i2cram_pkg and i2c_register_access_master_top_macros.svh.
//
//  Channel | Direction | Handshake           | Contents
//  s_      | in        | s_tvalid / s_tready | tick, optional command start, sampled SDA
//  m_      | out       | m_tvalid / m_tready | line levels, busy, done, last read byte
//  cfg_    | in        | cfg_valid/cfg_ready | seven-bit device address
//
// The sequencer state and the result register are updated on the edge that accepts
// an item, so one item per cycle is sustained while m_tready is high.
// The single result register frees up as it is taken, so s_tready stays high
// while m_tready is high; it drops only while a result waits and m_tready is low.
// Reset (aresetn low, synchronous) returns to idle, both lines high, address 24.
// cfg_ready is always high.
`include "i2c_register_access_master_top_macros.svh"

module i2c_register_access_master_top
    import i2cram_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // Input items.
    input  logic                s_tvalid,
    output logic                s_tready,
    // tdata from bit 0: register_index[7:0], write_data[15:8], sda_in[16], zero[23:17]
    input  logic [S_DATA_W-1:0] s_tdata,
    // tuser from bit 0: mode[1:0]
    input  logic [1:0]          s_tuser,
    // Result items.
    output logic                m_tvalid,
    input  logic                m_tready,
    // tdata from bit 0: scl[0], sda[1], busy_res[2], done_res[3], read_data[11:4],
    // zero[15:12]
    output logic [M_DATA_W-1:0] m_tdata,
    // Configuration write.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data
);

    phase_t              phase_reg, phase_next;
    stage_t              stage_reg, stage_next;
    logic [BITCNT_W-1:0] bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]   shift_byte_reg, shift_byte_next;
    logic [BYTE_W-1:0]   captured_reg, captured_next;
    logic [BYTE_W-1:0]   held_register_reg, held_register_next;
    logic [BYTE_W-1:0]   held_data_reg, held_data_next;
    logic                is_read_reg, is_read_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                done_next;
    logic [ADDR_W-1:0]   dev_addr_reg;
    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic                s_accept;
    logic [BYTE_W-1:0]   addr_byte;
    logic [BYTE_W-1:0]   in_register;
    logic [BYTE_W-1:0]   in_data;
    logic                in_sda;

    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign in_register = s_tdata[BYTE_W-1:0];
    assign in_data     = s_tdata[2*BYTE_W-1:BYTE_W];
    assign in_sda      = s_tdata[2*BYTE_W];
    assign addr_byte   = {dev_addr_reg, 1'b0};

    // Device address register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= ADDR_W'(24);
        end else if (cfg_valid && cfg_ready) begin
            dev_addr_reg <= cfg_data;
        end
    end

    // Sequencer state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            stage_reg         <= STAGE_ADDR_W;
            bit_count_reg     <= '0;
            shift_byte_reg    <= '0;
            captured_reg      <= '0;
            held_register_reg <= '0;
            held_data_reg     <= '0;
            is_read_reg       <= 1'b0;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
        end else begin
            phase_reg         <= phase_next;
            stage_reg         <= stage_next;
            bit_count_reg     <= bit_count_next;
            shift_byte_reg    <= shift_byte_next;
            captured_reg      <= captured_next;
            held_register_reg <= held_register_next;
            held_data_reg     <= held_data_next;
            is_read_reg       <= is_read_next;
            scl_reg           <= scl_next;
            sda_reg           <= sda_next;
        end
    end

    // Next state: one line change for each accepted item.
    always_comb begin
        phase_next         = phase_reg;
        stage_next         = stage_reg;
        bit_count_next     = bit_count_reg;
        shift_byte_next    = shift_byte_reg;
        captured_next      = captured_reg;
        held_register_next = held_register_reg;
        held_data_next     = held_data_reg;
        is_read_next       = is_read_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        done_next          = 1'b0;
        if (s_accept) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    // Only the two start codes begin a transaction.
                    if (s_tuser == MODE_WRITE || s_tuser == MODE_READ) begin
                        is_read_next       = (s_tuser == MODE_READ);
                        held_register_next = in_register;
                        held_data_next     = in_data;
                        sda_next           = 1'b0;
                        phase_next         = PH_START_LOW;
                    end
                end
                PH_START_LOW: begin
                    scl_next        = 1'b0;
                    shift_byte_next = addr_byte;
                    bit_count_next  = '0;
                    stage_next      = STAGE_ADDR_W;
                    phase_next      = PH_TX_SET;
                end
                PH_TX_SET: begin
                    sda_next   = shift_byte_reg[BYTE_W-1];
                    phase_next = PH_TX_HIGH;
                end
                PH_TX_HIGH: begin
                    scl_next   = 1'b1;
                    phase_next = PH_TX_LOW;
                end
                PH_TX_LOW: begin
                    scl_next        = 1'b0;
                    shift_byte_next = {shift_byte_reg[BYTE_W-2:0], 1'b0};
                    bit_count_next  = bit_count_reg + BITCNT_W'(1);
                    phase_next      = (bit_count_next >= BITCNT_W'(BYTE_W)) ? PH_ACK_REL
                                                                            : PH_TX_SET;
                end
                PH_ACK_REL: begin
                    sda_next   = 1'b1;
                    phase_next = PH_ACK_HIGH;
                end
                PH_ACK_HIGH: begin
                    scl_next   = 1'b1;
                    phase_next = PH_ACK_LOW;
                end
                PH_ACK_LOW: begin
                    scl_next = 1'b0;
                    // Pick what follows from the byte that was just sent.
                    case (stage_reg)
                        STAGE_ADDR_W: begin
                            shift_byte_next = held_register_reg;
                            bit_count_next  = '0;
                            stage_next      = STAGE_REG;
                            phase_next      = PH_TX_SET;
                        end
                        STAGE_REG: begin
                            if (is_read_reg) begin
                                phase_next = PH_RS_HIGH;
                            end else begin
                                shift_byte_next = held_data_reg;
                                bit_count_next  = '0;
                                stage_next      = STAGE_DATA;
                                phase_next      = PH_TX_SET;
                            end
                        end
                        STAGE_DATA: begin
                            phase_next = PH_SP_SDA;
                        end
                        default: begin
                            shift_byte_next = '0;
                            bit_count_next  = '0;
                            phase_next      = PH_RX_HIGH;
                        end
                    endcase
                end
                PH_RS_HIGH: begin
                    scl_next   = 1'b1;
                    phase_next = PH_RS_SDA;
                end
                PH_RS_SDA: begin
                    sda_next   = 1'b0;
                    phase_next = PH_RS_LOW;
                end
                PH_RS_LOW: begin
                    scl_next        = 1'b0;
                    shift_byte_next = {dev_addr_reg, 1'b1};
                    bit_count_next  = '0;
                    stage_next      = STAGE_ADDR_R;
                    phase_next      = PH_TX_SET;
                end
                PH_RX_HIGH: begin
                    // Sample on the rising SCL while data bits remain; the SCL pulse after the byte is the NACK.
                    scl_next = 1'b1;
                    if (bit_count_reg < BITCNT_W'(BYTE_W)) begin
                        shift_byte_next = {shift_byte_reg[BYTE_W-2:0], in_sda};
                    end
                    phase_next = PH_RX_LOW;
                end
                PH_RX_LOW: begin
                    scl_next = 1'b0;
                    if (bit_count_reg < BITCNT_W'(BYTE_W)) begin
                        bit_count_next = bit_count_reg + BITCNT_W'(1);
                        phase_next     = PH_RX_HIGH;
                    end else begin
                        phase_next = PH_SP_SDA;
                    end
                end
                PH_SP_SDA: begin
                    sda_next   = 1'b0;
                    phase_next = PH_SP_SCL;
                end
                PH_SP_SCL: begin
                    scl_next   = 1'b1;
                    phase_next = PH_SP_END;
                end
                PH_SP_END: begin
                    sda_next = 1'b1;
                    if (is_read_reg) begin
                        captured_next = shift_byte_reg;
                    end
                    done_next  = 1'b1;
                    phase_next = PH_IDLE;
                end
                default: begin
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Result register: loaded on accept, emptied when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {4'b0000, captured_next, done_next, (phase_next != PH_IDLE),
                           sda_next, scl_next};
        end
    end

    // Checks on the sequencer.
    `I2CRAM_ASSERT_NOW(a_idle_lines_high, aclk, aresetn, phase_reg == PH_IDLE,
        scl_reg && sda_reg, "idle with a bus line held low")
    `I2CRAM_ASSERT_NOW(a_bit_count_range, aclk, aresetn, 1'b1,
        bit_count_reg <= BITCNT_W'(BYTE_W), "bit counter past one byte")
    `I2CRAM_ASSERT_NOW(a_done_not_busy, aclk, aresetn, m_valid_reg && m_data_reg[3],
        !m_data_reg[2] && m_data_reg[1] && m_data_reg[0], "done reported without a finished stop")
    `I2CRAM_ASSERT_NEXT(a_tick_stays_idle, aclk, aresetn,
        s_accept && phase_reg == PH_IDLE && s_tuser == MODE_TICK,
        phase_reg == PH_IDLE, "plain tick left idle")

endmodule
